FILE: hdl/rgh_pkg.sv
// Shared types, constants and the cotangent table builder for the
// horizontal grid-line ray caster. No dependencies.
package rgh_pkg;

    localparam int MAP_SIDE    = 64;
    localparam int CELL_SHIFT  = 6;
    localparam int ANGLE_STEPS = 4096;
    localparam int FRAC_BITS   = 8;

    localparam int PIX_SHIFT   = CELL_SHIFT + FRAC_BITS;     // cell size in Q bits
    localparam int SIDE_W      = $clog2(MAP_SIDE);
    localparam int CELL_ADDR_W = 2 * SIDE_W;
    localparam int MAP_CELLS   = MAP_SIDE * MAP_SIDE;
    localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
    localparam int HALF_TURN   = ANGLE_STEPS / 2;
    localparam int QUARTER     = ANGLE_STEPS / 4;
    localparam int COT_ENTRIES = QUARTER + 1;
    localparam int COT_ADDR_W  = $clog2(COT_ENTRIES);

    localparam int COORD_W     = 20;
    localparam int DIST_W      = 21;
    localparam int REG_W       = 7;
    localparam int CFG_ADDR_W  = 2;
    localparam int COT_W       = 24;                         // magnitude, max 128.0 in Q16
    localparam int RX_W        = 25;                         // signed ray x
    localparam int RY_W        = 22;                         // signed ray y
    localparam int DY_W        = PIX_SHIFT + 1;              // |dy| up to one cell
    localparam int OFS_W       = 23;                         // rounded product magnitude
    localparam int MUL_A_W     = 21;
    localparam int PROD_W      = MUL_A_W + COT_W;
    localparam int SQ_IN_W     = 42;
    localparam int SQ_OUT_W    = SQ_IN_W / 2;
    localparam int STEP_W      = REG_W;

    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(1482912);

    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_WIDTH  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_MAP_HEIGHT = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_STEPS  = CFG_ADDR_W'(2);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ROM, ST_MUL_DY, ST_MUL_XO, ST_XO_FIN,
        ST_CHECK, ST_LOOK, ST_SQ_X, ST_SQ_Y, ST_SQ_ADD, ST_SQRT, ST_DONE
    } rgh_state_t;

    // Restoring long division, elaboration only
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo, rem;
        quo = 0;
        rem = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Cotangent magnitude of a quarter-turn angle index, Q16, elaboration only
    function automatic logic [COT_W-1:0] cot_mag(input int unsigned t);
        longint unsigned x, x2, ts, tc, v;
        longint signed   ss, cc;
        longint unsigned pi_q30;
        longint unsigned one_q30;
        pi_q30  = 64'd3373259426;
        one_q30 = 64'd1 << 30;
        x   = (longint'(t) * pi_q30) >> (ANGLE_W - 1);
        x2  = (x * x) >> 30;
        ts  = x;
        tc  = one_q30;
        ss  = longint'(x);
        cc  = longint'(one_q30);
        for (int k = 1; k <= 6; k++) begin
            ts = udiv64((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
            tc = udiv64((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1) begin
                ss = ss - longint'(ts);
                cc = cc - longint'(tc);
            end else begin
                ss = ss + longint'(ts);
                cc = cc + longint'(tc);
            end
        end
        if (cc < 0) cc = 0;
        if (ss <= 0) begin
            v = 64'd1 << 23;
        end else begin
            v = udiv64(longint'(cc) << 16, longint'(ss));
            if (v > (64'd1 << 23)) v = 64'd1 << 23;
        end
        return v[COT_W-1:0];
    endfunction

endpackage

FILE: hdl/rgh_cot_rom.sv
// Cotangent magnitude table over a quarter turn, built at elaboration.
// Depends on rgh_pkg.
module rgh_cot_rom (
    input  logic                           aclk,
    input  logic [rgh_pkg::COT_ADDR_W-1:0] addr,
    output logic [rgh_pkg::COT_W-1:0]      rom_q
);
    import rgh_pkg::*;

    logic [COT_W-1:0] cot_tbl [0:COT_ENTRIES-1];

    for (genvar g = 0; g < COT_ENTRIES; g++) begin : g_tbl
        localparam logic [COT_W-1:0] ENTRY = cot_mag(g);
        assign cot_tbl[g] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        rom_q <= cot_tbl[addr];
    end
endmodule

FILE: hdl/rgh_map_ram.sv
// Wall map: one bit per cell, one write and one registered read port.
// Depends on rgh_pkg.
module rgh_map_ram (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [rgh_pkg::CELL_ADDR_W-1:0] wr_addr,
    input  logic                            wr_data,
    input  logic [rgh_pkg::CELL_ADDR_W-1:0] rd_addr,
    output logic                            rd_data
);
    import rgh_pkg::*;

    logic mem [0:MAP_CELLS-1];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

FILE: hdl/rgh_isqrt.sv
// Bit-pair integer square root, one result bit per cycle.
// Depends on rgh_pkg.
module rgh_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [rgh_pkg::SQ_IN_W-1:0]  value,
    output logic                         done,
    output logic [rgh_pkg::SQ_OUT_W-1:0] root
);
    import rgh_pkg::*;

    localparam int CNT_W = $clog2(SQ_OUT_W + 1);

    logic [SQ_IN_W-1:0]  val_reg;
    logic [SQ_OUT_W+1:0] rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic [SQ_OUT_W+1:0] cand, trial;
    logic                take;

    assign cand  = {rem_reg[SQ_OUT_W-1:0], val_reg[SQ_IN_W-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign take  = (cand >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SQ_OUT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= take ? (cand - trial) : cand;
            root_reg <= {root_reg[SQ_OUT_W-2:0], take};
        end
    end

    assign root = root_reg;
endmodule

FILE: hdl/ray_grid_horizontal_hit.sv
// Horizontal grid-line ray caster over a 64 x 64 wall map of 64-pixel cells, Q12.8 coordinates.
// After reset the map is cleared one cell a cycle, with s_tready low. A map write is done in
// its transfer cycle. A horizontal ray goes from its transfer cycle straight to the output
// register. Any other cast is set up through the cotangent table and the shared multiplier
// (ST_ROM to ST_XO_FIN), visits each cell row with a bounds check and then a map read, makes a
// last bounds check on a miss, on a hit squares the offsets and runs the bit-serial square root,
// then loads the output register. A ray crosses at most 63 rows; s_tready is low meanwhile.
// The output register lets a result wait for m_tready while the next item is taken; a cast
// that finishes while the register is still full waits until it drains.
module ray_grid_horizontal_hit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_index[11:0], cell_wall[12], start_x[32:13], start_y[52:33], ray_angle[64:53]
    input  logic [rgh_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // hit_x[19:0], hit_y[39:20], distance[60:40]
    output logic [rgh_pkg::M_TDATA_W-1:0]      m_tdata,
    // hit[0]
    output logic                               m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [rgh_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rgh_pkg::REG_W-1:0]          cfg_wr_data
);
    import rgh_pkg::*;

    rgh_state_t state_reg, state_next;

    logic [REG_W-1:0] width_reg, height_reg, steps_reg;
    logic [REG_W-1:0] w_eff, h_eff;

    logic [CELL_ADDR_W-1:0] clr_reg;
    logic [COORD_W-1:0]     sx_reg, sy_reg;
    logic                   up_reg, neg_reg;
    logic [COT_ADDR_W-1:0]  cot_addr_reg;
    logic [COT_W-1:0]       cot_q;
    logic signed [RX_W-1:0] rx_reg, xo_reg;
    logic signed [RY_W-1:0] ry_reg;
    logic [STEP_W-1:0]      n_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [SQ_IN_W-1:0]     sum_reg;

    logic                   hit_reg;
    logic [COORD_W-1:0]     ox_reg, oy_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic                   m_valid_reg;

    logic [MUL_A_W-1:0]     mul_a;
    logic [COT_W-1:0]       mul_b;
    logic [OFS_W-1:0]       rnd_mag;
    logic signed [RX_W-1:0] ofs;
    logic [DY_W-1:0]        dy_mag;
    logic signed [RX_W:0]   dx_s;
    logic signed [RY_W:0]   dy_s;
    logic [MUL_A_W-1:0]     ux, uy;
    logic [RX_W-PIX_SHIFT-1:0] mx;
    logic [RY_W-PIX_SHIFT-1:0] my;
    logic                   out_of_map;
    logic                   ram_wr_en, ram_wr_data, ram_rd;
    logic [CELL_ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
    logic                   sq_start, sq_done;
    logic [SQ_OUT_W-1:0]    sq_root;
    logic                   in_xfer, out_free;
    logic                   fin_hit;
    logic [ANGLE_W-2:0]     t_mod;
    logic [ANGLE_W-1:0]     in_ang;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign w_eff    = (width_reg  > REG_W'(MAP_SIDE)) ? REG_W'(MAP_SIDE) : width_reg;
    assign h_eff    = (height_reg > REG_W'(MAP_SIDE)) ? REG_W'(MAP_SIDE) : height_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= REG_W'(64);
            height_reg <= REG_W'(64);
            steps_reg  <= REG_W'(127);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MAP_WIDTH:  width_reg  <= cfg_wr_data;
                CFG_MAP_HEIGHT: height_reg <= cfg_wr_data;
                CFG_MAX_STEPS:  steps_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // reduce the angle modulo a half turn for the table
    assign in_ang = s_tdata[64:53];
    assign t_mod  = in_ang[ANGLE_W-2:0];

    rgh_cot_rom u_cot (
        .aclk  (aclk),
        .addr  (cot_addr_reg),
        .rom_q (cot_q)
    );

    // shared multiplier, product registered
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_DY: begin mul_a = MUL_A_W'(dy_mag); mul_b = cot_q; end
            ST_MUL_XO: begin mul_a = MUL_A_W'(1 << PIX_SHIFT); mul_b = cot_q; end
            ST_SQ_X:   begin mul_a = ux; mul_b = COT_W'(ux); end
            ST_SQ_Y:   begin mul_a = uy; mul_b = COT_W'(uy); end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    logic [PROD_W-1:0] rnd_full;
    assign rnd_full = (prod_reg + PROD_W'(32768)) >> 16;
    assign rnd_mag  = rnd_full[OFS_W-1:0];
    assign ofs      = (up_reg ^ neg_reg) ? -$signed(RX_W'(rnd_mag)) : $signed(RX_W'(rnd_mag));

    assign dy_mag = up_reg ? (DY_W'(sy_reg[PIX_SHIFT-1:0]) + DY_W'(1))
                           : (DY_W'(1 << PIX_SHIFT) - DY_W'(sy_reg[PIX_SHIFT-1:0]));

    assign dx_s = $signed({rx_reg[RX_W-1], rx_reg}) - $signed({1'b0, RX_W'(sx_reg)});
    assign dy_s = $signed({ry_reg[RY_W-1], ry_reg}) - $signed({1'b0, RY_W'(sy_reg)});
    assign ux   = dx_s[RX_W] ? MUL_A_W'(-dx_s) : MUL_A_W'(dx_s);
    assign uy   = dy_s[RY_W] ? MUL_A_W'(-dy_s) : MUL_A_W'(dy_s);

    assign mx = rx_reg[RX_W-1:PIX_SHIFT];
    assign my = ry_reg[RY_W-1:PIX_SHIFT];
    assign out_of_map = rx_reg[RX_W-1] || ry_reg[RY_W-1]
                        || (mx >= ($bits(mx))'(w_eff)) || (my >= ($bits(my))'(h_eff));

    // wall map and its clearing pass
    assign ram_wr_en   = (state_reg == ST_CLEAR) || (in_xfer && s_tuser == CMD_WRITE);
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_reg : s_tdata[CELL_ADDR_W-1:0];
    assign ram_wr_data = (state_reg == ST_CLEAR) ? 1'b0 : s_tdata[12];
    assign ram_rd_addr = {my[SIDE_W-1:0], mx[SIDE_W-1:0]};

    rgh_map_ram u_map (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    assign sq_start = (state_reg == ST_SQ_ADD);

    rgh_isqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   (sum_reg + SQ_IN_W'(prod_reg)),
        .done    (sq_done),
        .root    (sq_root)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == CELL_ADDR_W'(MAP_CELLS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == CMD_CAST) begin
                    if (t_mod == '0) state_next = ST_DONE;
                    else             state_next = ST_ROM;
                end
            end
            ST_ROM:    state_next = ST_MUL_DY;
            ST_MUL_DY: state_next = ST_MUL_XO;
            ST_MUL_XO: state_next = ST_XO_FIN;
            ST_XO_FIN: state_next = ST_CHECK;
            ST_CHECK: begin
                if (n_reg >= steps_reg || out_of_map) state_next = ST_DONE;
                else                                   state_next = ST_LOOK;
            end
            ST_LOOK:   state_next = ram_rd ? ST_SQ_X : ST_CHECK;
            ST_SQ_X:   state_next = ST_SQ_Y;
            ST_SQ_Y:   state_next = ST_SQ_ADD;
            ST_SQ_ADD: state_next = ST_SQRT;
            ST_SQRT:   if (sq_done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                sx_reg  <= s_tdata[32:13];
                sy_reg  <= s_tdata[52:33];
                up_reg  <= (in_ang > ANGLE_W'(HALF_TURN));
                neg_reg <= (t_mod > (ANGLE_W-1)'(QUARTER));
                cot_addr_reg <= (t_mod > (ANGLE_W-1)'(QUARTER))
                                ? COT_ADDR_W'(ANGLE_W'(HALF_TURN) - ANGLE_W'(t_mod))
                                : COT_ADDR_W'(t_mod);
                n_reg   <= '0;
                fin_hit <= 1'b0;
            end
            ST_ROM: begin
                if (up_reg)
                    ry_reg <= $signed(RY_W'({sy_reg[COORD_W-1:PIX_SHIFT], PIX_SHIFT'(0)}))
                              - RY_W'(1);
                else
                    ry_reg <= $signed(RY_W'({sy_reg[COORD_W-1:PIX_SHIFT], PIX_SHIFT'(0)}))
                              + RY_W'(1 << PIX_SHIFT);
            end
            ST_MUL_XO: rx_reg <= $signed(RX_W'(sx_reg)) + ofs;
            ST_XO_FIN: xo_reg <= ofs;
            ST_LOOK: begin
                if (ram_rd) begin
                    fin_hit <= 1'b1;
                end else begin
                    rx_reg <= rx_reg + xo_reg;
                    ry_reg <= up_reg ? ry_reg - RY_W'(1 << PIX_SHIFT)
                                     : ry_reg + RY_W'(1 << PIX_SHIFT);
                    n_reg  <= n_reg + 1'b1;
                end
            end
            ST_SQ_Y: sum_reg <= SQ_IN_W'(prod_reg);
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_DONE && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DONE && out_free) begin
            hit_reg <= fin_hit;
            if (fin_hit) begin
                ox_reg   <= rx_reg[COORD_W-1:0];
                oy_reg   <= ry_reg[COORD_W-1:0];
                dist_reg <= (SQ_OUT_W'(sq_root) > SQ_OUT_W'(DIST_MAX)) ? DIST_MAX
                                                                       : DIST_W'(sq_root);
            end else begin
                ox_reg   <= sx_reg;
                oy_reg   <= sy_reg;
                dist_reg <= DIST_MAX;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tdata  = {3'b000, dist_reg, oy_reg, ox_reg};
endmodule

FILE: hdl/rgh_checker.sv
// Port-level checks for the ray caster, bound to the top level.
// Depends on rgh_pkg.
module rgh_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rgh_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import rgh_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    a_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("ready during map clear");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[60:40] == DIST_MAX)
        else $error("miss without maximum distance");

    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == CMD_WRITE |=> !$rose(m_tvalid))
        else $error("map write produced a result");
endmodule

bind ray_grid_horizontal_hit rgh_checker u_rgh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/tb_top.sv
// Self-checking testbench for ray_grid_horizontal_hit: map writes and ray casts go in over
// the input stream, cast results are predicted here and compared field by field.
// Depends on rgh_pkg and the ray_grid_horizontal_hit RTL.
`timescale 1ns / 100ps

module tb_top;
    import rgh_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [19:0] hx;
        logic [19:0] hy;
        logic [20:0] distance;
    } cast_res_t;

    typedef struct {
        logic        cmd;
        logic [11:0] idx;
        logic        wall;
        logic [19:0] sx;
        logic [19:0] sy;
        logic [11:0] ang;
        logic        chk;      // typed-in expectation present
        cast_res_t   want;
    } stim_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [REG_W-1:0] cfg_wr_data = '0;

    ray_grid_horizontal_hit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // predictor state
    bit          walls [MAP_CELLS];
    int unsigned width_q = 64, height_q = 64, steps_q = 127;
    cast_res_t   pending_casts [$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    bit          stall_on = 1'b0;

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint cot_q16(input int unsigned a);
        int unsigned t;
        bit neg;
        longint unsigned x, x2, ts, tc, v;
        longint ss, cc;
        t = a % HALF_TURN;
        neg = 1'b0;
        if (2 * t > HALF_TURN) begin
            t = HALF_TURN - t;
            neg = 1'b1;
        end
        x = (longint'(t) * 64'd3373259426) / HALF_TURN;
        x2 = (x * x) >> 30;
        ts = x;
        tc = 64'd1 << 30;
        ss = x;
        cc = tc;
        for (int k = 1; k <= 6; k++) begin
            ts = ((ts * x2) >> 30) / ((2 * k) * (2 * k + 1));
            tc = ((tc * x2) >> 30) / ((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                ss -= ts;
                cc -= tc;
            end else begin
                ss += ts;
                cc += tc;
            end
        end
        if (cc < 0) cc = 0;
        if (ss <= 0) v = 64'd1 << 23;
        else begin
            v = ($unsigned(cc) << 16) / $unsigned(ss);
            if (v > (64'd1 << 23)) v = 64'd1 << 23;
        end
        return neg ? -longint'(v) : longint'(v);
    endfunction

    function automatic longint round_mul(input longint a, input longint c);
        longint p;
        p = a * c;
        if (p < 0) return -((-p + 32768) >>> 16);
        return (p + 32768) >>> 16;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic cast_res_t trace_ray(input logic [19:0] sx, input logic [19:0] sy,
                                            input logic [11:0] ang);
        cast_res_t r;
        longint cot, line, rx, ry, xo, yo, dx, dy;
        longint unsigned mx, my, w, h;
        r.hit = 1'b0;
        r.hx = sx;
        r.hy = sy;
        r.distance = DIST_MAX;
        if (ang == 0 || ang == HALF_TURN) return r;
        cot = cot_q16(ang);
        line = (longint'(sy) >> PIX_SHIFT) << PIX_SHIFT;
        w = width_q > MAP_SIDE ? MAP_SIDE : width_q;
        h = height_q > MAP_SIDE ? MAP_SIDE : height_q;
        if (ang > HALF_TURN) begin
            ry = line - 1;
            yo = -(64'sd1 << PIX_SHIFT);
        end else begin
            ry = line + (64'sd1 << PIX_SHIFT);
            yo = 64'sd1 << PIX_SHIFT;
        end
        rx = longint'(sx) + round_mul(ry - longint'(sy), cot);
        xo = round_mul(yo, cot);
        for (int unsigned n = 0; n < steps_q; n++) begin
            if (rx < 0 || ry < 0) break;
            mx = rx >> PIX_SHIFT;
            my = ry >> PIX_SHIFT;
            if (mx >= w || my >= h) break;
            if (walls[my * MAP_SIDE + mx]) begin
                dx = rx - longint'(sx);
                dy = ry - longint'(sy);
                if (dx < 0) dx = -dx;
                if (dy < 0) dy = -dy;
                r.hit = 1'b1;
                r.hx = rx[19:0];
                r.hy = ry[19:0];
                mx = int_sqrt(dx * dx + dy * dy);
                r.distance = mx > DIST_MAX ? DIST_MAX : mx[20:0];
                break;
            end
            rx += xo;
            ry += yo;
        end
        return r;
    endfunction

    // result side: sample at rising edge, stall at random
    always @(posedge aclk) begin
        cast_res_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[19:0], m_tdata[39:20], m_tdata[60:40]};
            if (pending_casts.size() == 0) report("unexpected result", got.hx, 0);
            else begin
                want = pending_casts.pop_front();
                if (got.hit !== want.hit) report("hit", got.hit, want.hit);
                if (got.hx !== want.hx) report("hit_x", got.hx, want.hx);
                if (got.hy !== want.hy) report("hit_y", got.hy, want.hy);
                if (got.distance !== want.distance)
                    report("distance", got.distance, want.distance);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
        m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
    end

    int unsigned burst_left = 0;

    // drive one item; a checked row compares its typed result with the predictor
    task automatic send(input stim_t s);
        cast_res_t p;
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tuser <= s.cmd;
        s_tdata <= {7'b0, s.ang, s.sy, s.sx, s.wall, s.idx};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (s.cmd == CMD_WRITE) begin
            if (s.idx < MAP_CELLS) walls[s.idx] = s.wall;
        end else begin
            p = trace_ray(s.sx, s.sy, s.ang);
            if (s.chk && p !== s.want) report("table row", p.distance, s.want.distance);
            pending_casts.push_back(s.chk ? s.want : p);
        end
        @(negedge aclk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending_casts.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        @(negedge aclk);
    endtask

    // leaves the write enable high; the caller drops it after the last register
    task automatic set_reg(input logic [CFG_ADDR_W-1:0] a, input int unsigned v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= a;
        cfg_wr_data <= REG_W'(v);
        @(negedge aclk);
        v &= 7'h7f;
        if (a == CFG_MAP_WIDTH) width_q = v;
        else if (a == CFG_MAP_HEIGHT) height_q = v;
        else if (a == CFG_MAX_STEPS) steps_q = v;
    endtask

    function automatic stim_t wr(input int unsigned i, input bit w);
        stim_t s;
        s = '{CMD_WRITE, i[11:0], w, 20'($urandom()), 20'($urandom()), 12'($urandom()),
              1'b0, '0};
        return s;
    endfunction

    function automatic stim_t cast(input int unsigned x, input int unsigned y,
                                   input int unsigned a);
        stim_t s;
        s = '{CMD_CAST, 12'($urandom()), 1'($urandom()), x[19:0], y[19:0], a[11:0],
              1'b0, '0};
        return s;
    endfunction

    function automatic stim_t miss(input int unsigned x, input int unsigned y,
                                   input int unsigned a);
        stim_t s;
        s = cast(x, y, a);
        s.chk = 1'b1;
        s.want = '{1'b0, x[19:0], y[19:0], DIST_MAX};
        return s;
    endfunction

    initial begin
        stim_t table_rows [$];
        stim_t s;
        int unsigned col, row;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // empty map misses, horizontal rays, extremes, writes and a wall ahead
        table_rows = '{
            miss(20'h80080, 20'h80080, 1024), miss(20'hfffff, 20'hfffff, 3072),
            miss(0, 0, 0), miss(20'h40000, 20'h40000, HALF_TURN),
            miss(20'h40000, 20'h40000, 4095), miss(20'h40000, 20'h40000, 1),
            miss(0, 0, 3072), miss(20'h02000, 20'h00010, 2048 + 1),
            wr(4095, 1'b1), wr(0, 1'b1), wr(9 * 64 + 8, 1'b1), wr(7 * 64 + 8, 1'b1),
            wr(12'hfff, 1'b0),
            cast(20'h22000, 20'h22000, 1024), cast(20'h22000, 20'h22000, 3072),
            cast(20'h20000, 20'h20000, 1000), cast(20'h00100, 20'h00100, 1),
            cast(20'h3ffff, 20'h3ffff, 2047), cast(20'h22000, 20'h24000, 0),
            cast(20'hfc000, 20'hfc000, 3072), wr(9 * 64 + 8, 1'b0),
            cast(20'h22000, 20'h22000, 1024)
        };
        foreach (table_rows[i]) send(table_rows[i]);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin set_reg(CFG_MAP_WIDTH, 64); set_reg(CFG_MAP_HEIGHT, 64);
                         set_reg(CFG_MAX_STEPS, 127); end
                1: begin set_reg(CFG_MAP_WIDTH, 1); set_reg(CFG_MAP_HEIGHT, 64);
                         set_reg(CFG_MAX_STEPS, 1); end
                2: begin set_reg(CFG_MAP_WIDTH, 127); set_reg(CFG_MAP_HEIGHT, 127);
                         set_reg(CFG_MAX_STEPS, 20); end
                3: begin set_reg(CFG_MAP_WIDTH, 0); set_reg(CFG_MAP_HEIGHT, 1);
                         set_reg(CFG_MAX_STEPS, 0); end
                4: begin set_reg(CFG_MAP_WIDTH, 16); set_reg(CFG_MAP_HEIGHT, 16);
                         set_reg(CFG_MAX_STEPS, 64); end
                default: begin set_reg(CFG_MAP_WIDTH, $urandom_range(1, 127));
                         set_reg(CFG_MAP_HEIGHT, $urandom_range(1, 127));
                         set_reg(CFG_MAX_STEPS, $urandom_range(1, 127)); end
            endcase
            cfg_wr_en <= 1'b0;
            for (int n = 0; n < 200; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // bias writes to walls so casts meet something
                    s = wr($urandom_range(0, 4095), $urandom_range(0, 4) != 0);
                end else begin
                    // start mostly inside the map, angles cover the whole turn
                    col = $urandom_range(0, 63);
                    row = $urandom_range(0, 63);
                    s = cast((col << PIX_SHIFT) | $urandom_range(0, 16383),
                             (row << PIX_SHIFT) | $urandom_range(0, 16383),
                             $urandom_range(0, 4095));
                    if ($urandom_range(0, 15) == 0) s.sx = 20'($urandom());
                    if ($urandom_range(0, 15) == 0) s.sy = 20'($urandom());
                end
                send(s);
                if (n == 100) begin
                    // hold off until every outstanding result is back
                    s_tvalid <= 1'b0;
                    while (pending_casts.size() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
            end
            drain();
        end

        if (errors == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

FILE: sim.f
hdl/rgh_pkg.sv
hdl/rgh_cot_rom.sv
hdl/rgh_map_ram.sv
hdl/rgh_isqrt.sv
hdl/ray_grid_horizontal_hit.sv
hdl/rgh_checker.sv
tb/tb_top.sv
